@@ hdl/lsr_pkg.sv @@
// Shared types and constants for the LRU slot replacement block.
// No dependencies; used by lru_slot_replacement.
package lsr_pkg;

   // Default number of cache slots tracked by the replacement list.
   localparam int SLOTS_DEFAULT = 8192;

   // Width of a slot number as it travels on the ports.
   localparam int SLOT_W = 13;

   // Port data widths; the tdata widths are rounded up to whole bytes.
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 2;

   // Request command codes.
   localparam logic CMD_PUT   = 1'b0;
   localparam logic CMD_TOUCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UNLINK,
      ST_FINISH
   } state_type;

endpackage

@@ hdl/lsr_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; instanced for the link memories of lru_slot_replacement.
module lsr_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lru_slot_replacement.sv @@
// Top level of the LRU slot replacement block: sequencer, list pointers and output register.
// Depends on lsr_pkg and lsr_ram (two link memories, one toward older, one toward newer).
//
//   Channel | Direction | tdata           | tuser
//   req_    | in        | [12:0] slot     | [0] command, [1] lookup_hit
//   rsp_    | out       | [12:0] slot     | [0] evicted, [1] error
//
// A request that moves a slot within the list goes through these steps in order: accept
// and read the slot's links, unlink its neighbors, relink it at the newest end. Any other
// request skips the unlink step; each link memory has a single write port.
// Reset clears the list pointers and the fill count; no clearing pass is needed.
// A response waiting on rsp_ holds the sequencer in its last step, without any write.
module lru_slot_replacement #(
   parameter int SLOTS = lsr_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lsr_pkg::REQ_DATA_W-1:0] req_tdata,  // [12:0] slot
   input  logic [lsr_pkg::REQ_USER_W-1:0] req_tuser,  // [0] command, [1] lookup_hit
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lsr_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [12:0] slot_given
   output logic [lsr_pkg::RSP_USER_W-1:0] rsp_tuser   // [0] evicted, [1] error
);

   localparam int SW   = $clog2(SLOTS);
   localparam int CW   = $clog2(SLOTS + 1);
   localparam int CMPW = (CW > lsr_pkg::SLOT_W) ? CW : lsr_pkg::SLOT_W;

   lsr_pkg::state_type state_ff, state_in;

   logic [SW-1:0] slot_ff, slot_in;
   logic [SW-1:0] newest_ff, newest_in;
   logic [SW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] count_ff, count_in;
   logic          move_ff, move_in;
   logic          link_ff, link_in;
   logic          new_ff, new_in;

   logic [lsr_pkg::SLOT_W-1:0] given_ff, given_in;
   logic                       evicted_ff, evicted_in;
   logic                       error_ff, error_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [lsr_pkg::SLOT_W-1:0] rsp_given_ff, rsp_given_in;
   logic                       rsp_evicted_ff, rsp_evicted_in;
   logic                       rsp_error_ff, rsp_error_in;

   // Link memory ports.
   logic          nl_wr_en, pl_wr_en;
   logic [SW-1:0] nl_wr_addr, pl_wr_addr;
   logic [SW-1:0] nl_wr_data, pl_wr_data;
   logic [SW-1:0] rd_addr;
   logic [SW-1:0] next_rd, prev_rd;

   // Request decode.
   logic                       req_cmd;
   logic                       req_hit;
   logic [lsr_pkg::SLOT_W-1:0] req_slot;
   logic                       store_full;
   logic                       slot_held;
   logic                       out_free;

   assign req_cmd  = req_tuser[0];
   assign req_hit  = req_tuser[1];
   assign req_slot = req_tdata[lsr_pkg::SLOT_W-1:0];

   // Slots are handed out in order and never released, so a slot is held exactly
   // when its number is below the fill count.
   assign store_full = (count_ff == CW'(SLOTS));
   assign slot_held  = (CMPW'(req_slot) < CMPW'(count_ff));
   assign out_free   = !rsp_valid_ff || rsp_tready;

   lsr_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_next_link (
      .clock   (clock),
      .wr_en   (nl_wr_en),
      .wr_addr (nl_wr_addr),
      .wr_data (nl_wr_data),
      .rd_addr (rd_addr),
      .rd_data (next_rd)
   );

   lsr_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_prev_link (
      .clock   (clock),
      .wr_en   (pl_wr_en),
      .wr_addr (pl_wr_addr),
      .wr_data (pl_wr_data),
      .rd_addr (rd_addr),
      .rd_data (prev_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsr_pkg::ST_IDLE;
         newest_ff    <= '0;
         oldest_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         newest_ff    <= newest_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff        <= slot_in;
      move_ff        <= move_in;
      link_ff        <= link_in;
      new_ff         <= new_in;
      given_ff       <= given_in;
      evicted_ff     <= evicted_in;
      error_ff       <= error_in;
      rsp_given_ff   <= rsp_given_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_error_ff   <= rsp_error_in;
   end

   always_comb begin
      state_in       = state_ff;
      slot_in        = slot_ff;
      newest_in      = newest_ff;
      oldest_in      = oldest_ff;
      count_in       = count_ff;
      move_in        = move_ff;
      link_in        = link_ff;
      new_in         = new_ff;
      given_in       = given_ff;
      evicted_in     = evicted_ff;
      error_in       = error_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_given_in   = rsp_given_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_error_in   = rsp_error_ff;
      nl_wr_en       = 1'b0;
      nl_wr_addr     = slot_ff;
      nl_wr_data     = newest_ff;
      pl_wr_en       = 1'b0;
      pl_wr_addr     = newest_ff;
      pl_wr_data     = slot_ff;
      req_tready     = 1'b0;

      // Decode of the incoming request; only taken up in the idle state.
      if (req_cmd == lsr_pkg::CMD_TOUCH || req_hit) begin
         rd_addr = SW'(req_slot);
      end else if (store_full) begin
         rd_addr = oldest_ff;
      end else begin
         rd_addr = SW'(count_ff);
      end

      case (state_ff)
         lsr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               slot_in    = rd_addr;
               evicted_in = 1'b0;
               error_in   = 1'b0;
               new_in     = 1'b0;
               if (req_cmd == lsr_pkg::CMD_TOUCH || req_hit) begin
                  given_in = req_slot;
                  if (slot_held) begin
                     move_in = (rd_addr != newest_ff);
                  end else begin
                     move_in  = 1'b0;
                     error_in = 1'b1;
                  end
                  link_in = move_in;
               end else if (store_full) begin
                  given_in   = lsr_pkg::SLOT_W'(oldest_ff);
                  evicted_in = 1'b1;
                  move_in    = (oldest_ff != newest_ff);
                  link_in    = move_in;
               end else begin
                  given_in = lsr_pkg::SLOT_W'(count_ff);
                  new_in   = 1'b1;
                  move_in  = 1'b0;
                  // The very first slot has no neighbor to link to.
                  link_in  = (count_ff != '0);
               end
               state_in = move_in ? lsr_pkg::ST_UNLINK : lsr_pkg::ST_FINISH;
            end
         end

         lsr_pkg::ST_UNLINK: begin
            // Read data holds the slot's neighbors: prev_rd is newer, next_rd older.
            nl_wr_en   = 1'b1;
            nl_wr_addr = prev_rd;
            nl_wr_data = next_rd;
            if (slot_ff == oldest_ff) begin
               oldest_in = prev_rd;
            end else begin
               pl_wr_en   = 1'b1;
               pl_wr_addr = next_rd;
               pl_wr_data = prev_rd;
            end
            state_in = lsr_pkg::ST_FINISH;
         end

         lsr_pkg::ST_FINISH: begin
            if (out_free) begin
               if (link_ff) begin
                  nl_wr_en  = 1'b1;
                  pl_wr_en  = 1'b1;
                  newest_in = slot_ff;
               end
               if (new_ff) begin
                  count_in = count_ff + CW'(1);
                  if (count_ff == '0) begin
                     newest_in = slot_ff;
                     oldest_in = slot_ff;
                  end
               end
               rsp_valid_in   = 1'b1;
               rsp_given_in   = given_ff;
               rsp_evicted_in = evicted_ff;
               rsp_error_in   = error_ff;
               state_in       = lsr_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lsr_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = lsr_pkg::RSP_DATA_W'(rsp_given_ff);
   assign rsp_tuser  = {rsp_error_ff, rsp_evicted_ff};

   // The fill count never passes the number of slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SLOTS))
      else $error("fill count exceeds slot count");

   // An eviction is only reported once every slot is held.
   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lsr_pkg::ST_FINISH && out_free && evicted_ff) |-> store_full)
      else $error("eviction reported before the store filled");

   // Unlinking always hands over to the relink step in the next cycle.
   a_unlink_next: assert property (@(posedge clock) disable iff (reset)
      state_ff == lsr_pkg::ST_UNLINK |=> state_ff == lsr_pkg::ST_FINISH)
      else $error("unlink step not followed by relink");

   // An error response never comes with a change to the list.
   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lsr_pkg::ST_FINISH && error_ff) |-> (!nl_wr_en && !pl_wr_en))
      else $error("link memory written for a request on a slot not held");

endmodule
